FILE: sv/gmhp_pkg.sv
`timescale 1ns / 1ps

package gmhp_pkg;

   // Parse phase codes; codes 14 and 15 are unused and act as payload.
   typedef enum logic [3:0] {
      PH_ID1      = 4'd0,
      PH_ID2      = 4'd1,
      PH_CM       = 4'd2,
      PH_FLG      = 4'd3,
      PH_MTIME    = 4'd4,
      PH_XFL      = 4'd5,
      PH_OS       = 4'd6,
      PH_XLEN_LO  = 4'd7,
      PH_XLEN_HI  = 4'd8,
      PH_EXTRA    = 4'd9,
      PH_NAME     = 4'd10,
      PH_COMMENT  = 4'd11,
      PH_HCRC     = 4'd12,
      PH_PAYLOAD  = 4'd13
   } phase_type;

   typedef enum logic [2:0] {
      ST_HEADER   = 3'd0,
      ST_LAST     = 3'd1,
      ST_PAYLOAD  = 3'd2,
      ST_MAGIC    = 3'd3,
      ST_METHOD   = 3'd4,
      ST_FLAGS    = 3'd5,
      ST_XFL      = 3'd6
   } status_type;

   localparam logic [7:0] ID1_BYTE      = 8'd31;
   localparam logic [7:0] ID2_BYTE      = 8'd139;
   localparam logic [7:0] CM_DEFLATE    = 8'd8;
   localparam logic [7:0] FLG_RESERVED  = 8'he0;
   localparam logic [7:0] XFL_MAX       = 8'd2;
   localparam logic [7:0] XFL_FAST      = 8'd4;
   localparam logic [15:0] MTIME_BYTES  = 16'd4;
   localparam logic [15:0] HCRC_BYTES   = 16'd2;

   // Bit positions in the captured flag field.
   localparam int FL_HCRC    = 1;
   localparam int FL_EXTRA   = 2;
   localparam int FL_NAME    = 3;
   localparam int FL_COMMENT = 4;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] count;
      logic [4:0]  flags;
      status_type  err;
   } state_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  payload_byte;
      logic [4:0]  header_flags;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase: PH_ID1, count: 16'd0, flags: 5'd0, err: ST_HEADER};

   // First flagged optional section at or after 'from', else payload.
   function automatic phase_type next_section(phase_type from, logic [4:0] flags);
      phase_type res;
      res = PH_PAYLOAD;
      if (from <= PH_XLEN_LO && flags[FL_EXTRA]) begin
         res = PH_XLEN_LO;
      end else if (from <= PH_NAME && flags[FL_NAME]) begin
         res = PH_NAME;
      end else if (from <= PH_COMMENT && flags[FL_COMMENT]) begin
         res = PH_COMMENT;
      end else if (from <= PH_HCRC && flags[FL_HCRC]) begin
         res = PH_HCRC;
      end
      return res;
   endfunction

endpackage

FILE: sv/gmhp_if.sv
`timescale 1ns / 1ps

interface gmhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       new_member;

   modport source (output valid, output in_byte, output new_member, input ready);
   modport sink   (input valid, input in_byte, input new_member, output ready);
endinterface

interface gmhp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] payload_byte;
   logic [4:0] header_flags;

   modport source (output valid, output status, output payload_byte,
                   output header_flags, input ready);
   modport sink   (input valid, input status, input payload_byte,
                   input header_flags, output ready);
endinterface

FILE: sv/gmhp_step.sv
`timescale 1ns / 1ps

// One parse step: current state and one byte in, next state and result out.
module gmhp_step (
   input  gmhp_pkg::state_type  state_cur,
   input  logic [7:0]           in_byte,
   input  logic                 new_member,
   output gmhp_pkg::state_type  state_nxt,
   output gmhp_pkg::result_type result
);

   gmhp_pkg::state_type  eff;
   gmhp_pkg::state_type  nxt;
   gmhp_pkg::status_type status;
   logic [7:0]           payload;
   logic [15:0]          cnt_inc;
   logic [15:0]          cnt_dec;
   logic [15:0]          xlen;

   always_comb begin
      eff     = new_member ? gmhp_pkg::STATE_RESET : state_cur;
      nxt     = eff;
      status  = gmhp_pkg::ST_HEADER;
      payload = 8'd0;
      cnt_inc = eff.count + 16'd1;
      cnt_dec = (eff.count != 16'd0) ? eff.count - 16'd1 : eff.count;
      xlen    = {in_byte, eff.count[7:0]};

      if (eff.err != gmhp_pkg::ST_HEADER) begin
         // Hold the error: answer with it, touch nothing.
         status = eff.err;
      end else begin
         unique case (eff.phase)
            gmhp_pkg::PH_ID1: begin
               if (in_byte != gmhp_pkg::ID1_BYTE) nxt.err = gmhp_pkg::ST_MAGIC;
               else nxt.phase = gmhp_pkg::PH_ID2;
            end
            gmhp_pkg::PH_ID2: begin
               if (in_byte != gmhp_pkg::ID2_BYTE) nxt.err = gmhp_pkg::ST_MAGIC;
               else nxt.phase = gmhp_pkg::PH_CM;
            end
            gmhp_pkg::PH_CM: begin
               if (in_byte != gmhp_pkg::CM_DEFLATE) nxt.err = gmhp_pkg::ST_METHOD;
               else nxt.phase = gmhp_pkg::PH_FLG;
            end
            gmhp_pkg::PH_FLG: begin
               nxt.flags = in_byte[4:0];
               if ((in_byte & gmhp_pkg::FLG_RESERVED) != 8'd0) begin
                  nxt.err = gmhp_pkg::ST_FLAGS;
               end else begin
                  nxt.phase = gmhp_pkg::PH_MTIME;
                  nxt.count = 16'd0;
               end
            end
            gmhp_pkg::PH_MTIME: begin
               nxt.count = cnt_inc;
               if (cnt_inc >= gmhp_pkg::MTIME_BYTES) begin
                  nxt.count = 16'd0;
                  nxt.phase = gmhp_pkg::PH_XFL;
               end
            end
            gmhp_pkg::PH_XFL: begin
               if (in_byte != gmhp_pkg::XFL_MAX && in_byte != gmhp_pkg::XFL_FAST)
                  nxt.err = gmhp_pkg::ST_XFL;
               else nxt.phase = gmhp_pkg::PH_OS;
            end
            gmhp_pkg::PH_OS: begin
               nxt.phase = gmhp_pkg::next_section(gmhp_pkg::PH_XLEN_LO, eff.flags);
            end
            gmhp_pkg::PH_XLEN_LO: begin
               nxt.count = {8'd0, in_byte};
               nxt.phase = gmhp_pkg::PH_XLEN_HI;
            end
            gmhp_pkg::PH_XLEN_HI: begin
               nxt.count = xlen;
               nxt.phase = (xlen == 16'd0)
                  ? gmhp_pkg::next_section(gmhp_pkg::PH_NAME, eff.flags)
                  : gmhp_pkg::PH_EXTRA;
            end
            gmhp_pkg::PH_EXTRA: begin
               nxt.count = cnt_dec;
               if (cnt_dec == 16'd0)
                  nxt.phase = gmhp_pkg::next_section(gmhp_pkg::PH_NAME, eff.flags);
            end
            gmhp_pkg::PH_NAME: begin
               if (in_byte == 8'd0)
                  nxt.phase = gmhp_pkg::next_section(gmhp_pkg::PH_COMMENT, eff.flags);
            end
            gmhp_pkg::PH_COMMENT: begin
               if (in_byte == 8'd0)
                  nxt.phase = gmhp_pkg::next_section(gmhp_pkg::PH_HCRC, eff.flags);
            end
            gmhp_pkg::PH_HCRC: begin
               nxt.count = cnt_inc;
               if (cnt_inc >= gmhp_pkg::HCRC_BYTES) begin
                  nxt.count = 16'd0;
                  nxt.phase = gmhp_pkg::PH_PAYLOAD;
               end
            end
            default: begin
               nxt.phase = gmhp_pkg::PH_PAYLOAD;
               status    = gmhp_pkg::ST_PAYLOAD;
               payload   = in_byte;
            end
         endcase

         if (nxt.err != gmhp_pkg::ST_HEADER) begin
            status  = nxt.err;
            payload = 8'd0;
         end else if (status != gmhp_pkg::ST_PAYLOAD && nxt.phase == gmhp_pkg::PH_PAYLOAD) begin
            status = gmhp_pkg::ST_LAST;
         end
      end

      state_nxt           = nxt;
      result.status       = status;
      result.payload_byte = payload;
      result.header_flags = nxt.flags;
   end

endmodule

FILE: sv/gzip_member_header_parser_core.sv
`timescale 1ns / 1ps

// Channel   Role    Transaction payload
// req_ch    sink    in_byte[7:0], new_member
// rsp_ch    source  status[2:0], payload_byte[7:0], header_flags[4:0]
//
// One byte per cycle while req_ch is ready: each accepted req transaction produces
// exactly one rsp transaction, registered in the output stage.
// The parse step is a single combinational pass from the state registers to
// the result register; the state advances at the acceptance edge.
// A two-entry output stage (result register plus skid register) keeps req_ch
// ready while one result waits; req_ch stalls only when both entries are full.
// Synchronous active-high reset returns the parser to waiting for ID1 and
// empties the output stage.
module gzip_member_header_parser_core (
   input  logic        clock,
   input  logic        reset,
   gmhp_req_if.sink    req_ch,
   gmhp_rsp_if.source  rsp_ch
);

   gmhp_pkg::state_type  state_ff;
   gmhp_pkg::state_type  state_in;
   gmhp_pkg::result_type step_result;
   gmhp_pkg::result_type out_ff;
   gmhp_pkg::result_type skid_ff;
   logic                 out_valid_ff;
   logic                 skid_valid_ff;
   logic                 push;
   logic                 pop;

   // Parse one byte against the current state.
   gmhp_step u_step (
      .state_cur  (state_ff),
      .in_byte    (req_ch.in_byte),
      .new_member (req_ch.new_member),
      .state_nxt  (state_in),
      .result     (step_result)
   );

   // Accept whenever the skid entry is free.
   assign req_ch.ready = !skid_valid_ff;
   assign push         = req_ch.valid && req_ch.ready;
   assign pop          = out_valid_ff && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gmhp_pkg::STATE_RESET;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         // Advance the parser on each accepted transaction.
         if (push) state_ff <= state_in;

         if (push) begin
            if (!out_valid_ff || pop) begin
               out_ff       <= step_result;
               out_valid_ff <= 1'b1;
            end else begin
               // Output is stalled: park the result in the skid entry.
               skid_ff       <= step_result;
               skid_valid_ff <= 1'b1;
            end
         end else if (pop) begin
            if (skid_valid_ff) begin
               out_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.status       = out_ff.status;
   assign rsp_ch.payload_byte = out_ff.payload_byte;
   assign rsp_ch.header_flags = out_ff.header_flags;

   // The skid entry is only ever filled behind a full output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // A push against a stalled output must land in the skid entry.
   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (push && out_valid_ff && !rsp_ch.ready) |=> skid_valid_ff)
      else $error("result lost on stalled output");

   // A held error does not change until a new member starts.
   a_sticky_error: assert property (@(posedge clock) disable iff (reset)
      (push && !req_ch.new_member && state_ff.err != gmhp_pkg::ST_HEADER)
      |=> (state_ff.err == $past(state_ff.err)))
      else $error("sticky error changed without new_member");

   // Payload bytes appear only with payload status.
   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.payload_byte != 8'd0)
      |-> (out_ff.status == gmhp_pkg::ST_PAYLOAD))
      else $error("nonzero payload_byte on a header or error result");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

   // Cycles without any transaction on either channel before the run is called hung.
   localparam int STALL_LIMIT     = 2000;
   // Length of the deliberate receiver hold-off that backs the parser up.
   localparam int RSP_HOLD_CYCLES = 48;
   // Cycles to keep watching the result channel after the last expected result.
   localparam int DRAIN_CYCLES    = 8;

   // Ways a generated member header gets broken on purpose.
   typedef enum int {
      DMG_NONE,
      DMG_MAGIC,
      DMG_METHOD,
      DMG_FLAGS,
      DMG_XFL,
      DMG_CUT
   } damage_type;

   // Tracks the parser state for every accepted byte and holds the results it
   // must produce, oldest first.
   class gzip_header_tracker;
      gmhp_pkg::phase_type  phase;
      logic [15:0]          count;
      logic [4:0]           flags;
      gmhp_pkg::status_type fault;      // ST_HEADER while no error is held
      gmhp_pkg::result_type pending_results[$];
      int                   mismatches;

      function new();
         restart();
         mismatches = 0;
      endfunction

      function void restart();
         phase = gmhp_pkg::PH_ID1;
         count = '0;
         flags = '0;
         fault = gmhp_pkg::ST_HEADER;
      endfunction

      // Lowest flagged optional section at or after 'from'; payload if none.
      function gmhp_pkg::phase_type section_after(gmhp_pkg::phase_type from);
         gmhp_pkg::phase_type nxt;
         nxt = gmhp_pkg::PH_PAYLOAD;
         if (from <= gmhp_pkg::PH_HCRC && flags[gmhp_pkg::FL_HCRC])
            nxt = gmhp_pkg::PH_HCRC;
         if (from <= gmhp_pkg::PH_COMMENT && flags[gmhp_pkg::FL_COMMENT])
            nxt = gmhp_pkg::PH_COMMENT;
         if (from <= gmhp_pkg::PH_NAME && flags[gmhp_pkg::FL_NAME])
            nxt = gmhp_pkg::PH_NAME;
         if (from <= gmhp_pkg::PH_XLEN_LO && flags[gmhp_pkg::FL_EXTRA])
            nxt = gmhp_pkg::PH_XLEN_LO;
         return nxt;
      endfunction

      // Advance the parser state by one accepted byte and queue its result.
      function void accept_byte(logic [7:0] b, logic starts_member);
         gmhp_pkg::result_type r;
         gmhp_pkg::status_type st;
         logic [7:0]           pay;
         if (starts_member) restart();
         st  = gmhp_pkg::ST_HEADER;
         pay = '0;
         if (fault == gmhp_pkg::ST_HEADER) begin
            case (phase)
               gmhp_pkg::PH_ID1: begin
                  if (b != gmhp_pkg::ID1_BYTE) fault = gmhp_pkg::ST_MAGIC;
                  else phase = gmhp_pkg::PH_ID2;
               end
               gmhp_pkg::PH_ID2: begin
                  if (b != gmhp_pkg::ID2_BYTE) fault = gmhp_pkg::ST_MAGIC;
                  else phase = gmhp_pkg::PH_CM;
               end
               gmhp_pkg::PH_CM: begin
                  if (b != gmhp_pkg::CM_DEFLATE) fault = gmhp_pkg::ST_METHOD;
                  else phase = gmhp_pkg::PH_FLG;
               end
               gmhp_pkg::PH_FLG: begin
                  flags = b[4:0];
                  if ((b & gmhp_pkg::FLG_RESERVED) != 8'd0) begin
                     fault = gmhp_pkg::ST_FLAGS;
                  end else begin
                     phase = gmhp_pkg::PH_MTIME;
                     count = '0;
                  end
               end
               gmhp_pkg::PH_MTIME: begin
                  count = count + 16'd1;
                  if (count >= gmhp_pkg::MTIME_BYTES) begin
                     count = '0;
                     phase = gmhp_pkg::PH_XFL;
                  end
               end
               gmhp_pkg::PH_XFL: begin
                  if (b != gmhp_pkg::XFL_MAX && b != gmhp_pkg::XFL_FAST)
                     fault = gmhp_pkg::ST_XFL;
                  else phase = gmhp_pkg::PH_OS;
               end
               gmhp_pkg::PH_OS: phase = section_after(gmhp_pkg::PH_XLEN_LO);
               gmhp_pkg::PH_XLEN_LO: begin
                  count = {8'd0, b};
                  phase = gmhp_pkg::PH_XLEN_HI;
               end
               gmhp_pkg::PH_XLEN_HI: begin
                  count = {b, count[7:0]};
                  phase = (count == 16'd0) ? section_after(gmhp_pkg::PH_NAME)
                                           : gmhp_pkg::PH_EXTRA;
               end
               gmhp_pkg::PH_EXTRA: begin
                  if (count != 16'd0) count = count - 16'd1;
                  if (count == 16'd0) phase = section_after(gmhp_pkg::PH_NAME);
               end
               gmhp_pkg::PH_NAME: begin
                  if (b == 8'd0) phase = section_after(gmhp_pkg::PH_COMMENT);
               end
               gmhp_pkg::PH_COMMENT: begin
                  if (b == 8'd0) phase = section_after(gmhp_pkg::PH_HCRC);
               end
               gmhp_pkg::PH_HCRC: begin
                  count = count + 16'd1;
                  if (count >= gmhp_pkg::HCRC_BYTES) begin
                     count = '0;
                     phase = gmhp_pkg::PH_PAYLOAD;
                  end
               end
               default: begin
                  phase = gmhp_pkg::PH_PAYLOAD;
                  st    = gmhp_pkg::ST_PAYLOAD;
                  pay   = b;
               end
            endcase
         end
         if (fault != gmhp_pkg::ST_HEADER) begin
            st  = fault;
            pay = '0;
         end else if (st != gmhp_pkg::ST_PAYLOAD && phase == gmhp_pkg::PH_PAYLOAD) begin
            st = gmhp_pkg::ST_LAST;
         end
         r.status       = st;
         r.payload_byte = pay;
         r.header_flags = flags;
         pending_results.push_back(r);
      endfunction

      function void report(string field, int want, int got);
         $display("%0t ns: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                  $time, field, want, want, got, got);
         mismatches++;
      endfunction

      // Compare one accepted result against the oldest queued one.
      function void check_result(logic [2:0] st, logic [7:0] pay, logic [4:0] fl);
         gmhp_pkg::result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t ns: unexpected result, status %0d payload 0x%0h flags 0x%0h",
                     $time, st, pay, fl);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         if (st !== want.status) report("status", want.status, st);
         if (pay !== want.payload_byte) report("payload_byte", want.payload_byte, pay);
         if (fl !== want.header_flags) report("header_flags", want.header_flags, fl);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   gmhp_req_if req_ch ();
   gmhp_rsp_if rsp_ch ();

   gzip_member_header_parser_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   gzip_header_tracker tracker = new();

   int req_idle_pct     = 0;  // chance in 100 that the sender skips a cycle
   int rsp_idle_pct     = 0;  // chance in 100 that the receiver drops ready
   int bytes_sent       = 0;
   int idle_cycles      = 0;
   bit hold_off_request = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Monitor both channels on the same edge. Note the input transaction first so
   // a result is never compared before its byte has been tracked.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            tracker.accept_byte(req_ch.in_byte, req_ch.new_member);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            tracker.check_result(rsp_ch.status, rsp_ch.payload_byte, rsp_ch.header_flags);
         end
      end
   end

   // Watchdog: count cycles with no transaction at all; abort on a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("** gzip_member_header_parser_core: FAILED **");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Receiver: randomize ready every cycle. On request, hold ready low for a
   // long stretch so the output stage fills and the parser stalls its input.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Offer one byte; insert random idle cycles ahead of it, then hold it until
   // the transaction completes.
   task automatic send_byte(input logic [7:0] value, input logic first);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.in_byte    <= value;
      req_ch.new_member <= first;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
   endtask

   // Build one member: fixed header, the flagged optional sections, then a
   // short payload. Optionally break it, then send it with new_member on the
   // first byte.
   task automatic send_member(input logic [4:0] flg, input logic [15:0] xlen,
                              input damage_type damage);
      logic [7:0] bytes_out[$];
      int         keep;
      bytes_out = {gmhp_pkg::ID1_BYTE, gmhp_pkg::ID2_BYTE, gmhp_pkg::CM_DEFLATE,
                   {3'b000, flg}};
      repeat (4) bytes_out.push_back(8'($urandom_range(255)));         // MTIME
      bytes_out.push_back($urandom_range(1) ? gmhp_pkg::XFL_MAX : gmhp_pkg::XFL_FAST);
      bytes_out.push_back(8'($urandom_range(255)));                    // OS
      if (flg[gmhp_pkg::FL_EXTRA]) begin
         bytes_out.push_back(xlen[7:0]);
         bytes_out.push_back(xlen[15:8]);
         repeat (xlen) bytes_out.push_back(8'($urandom_range(255)));
      end
      if (flg[gmhp_pkg::FL_NAME]) begin
         repeat ($urandom_range(6)) bytes_out.push_back(8'($urandom_range(1, 255)));
         bytes_out.push_back(8'd0);
      end
      if (flg[gmhp_pkg::FL_COMMENT]) begin
         repeat ($urandom_range(6)) bytes_out.push_back(8'($urandom_range(1, 255)));
         bytes_out.push_back(8'd0);
      end
      if (flg[gmhp_pkg::FL_HCRC]) begin
         repeat (2) bytes_out.push_back(8'($urandom_range(255)));
      end
      repeat ($urandom_range(24)) bytes_out.push_back(8'($urandom_range(255)));

      case (damage)
         DMG_MAGIC: begin
            keep = $urandom_range(1);
            bytes_out[keep] = bytes_out[keep] ^ 8'($urandom_range(1, 255));
         end
         DMG_METHOD: bytes_out[2] = bytes_out[2] ^ 8'($urandom_range(1, 255));
         // Set at least one reserved flag bit; keep the low five as generated.
         DMG_FLAGS: bytes_out[3] = bytes_out[3]
                                   | (gmhp_pkg::FLG_RESERVED & 8'($urandom_range(1, 7) << 5));
         DMG_XFL: begin
            bytes_out[8] = 8'($urandom_range(255));
            if (bytes_out[8] == gmhp_pkg::XFL_MAX || bytes_out[8] == gmhp_pkg::XFL_FAST) begin
               bytes_out[8] = bytes_out[8] ^ 8'h01;
            end
         end
         // Truncate at a random point, possibly mid-header; the next member restarts the parser.
         DMG_CUT: begin
            keep = $urandom_range(1, bytes_out.size());
            bytes_out = bytes_out[0:keep-1];
         end
         default: ;
      endcase

      foreach (bytes_out[i]) send_byte(bytes_out[i], i == 0);
   endtask

   // One random unit of traffic: mostly well-formed members, some broken
   // members, and some raw noise with stray restarts.
   task automatic send_random_unit();
      int          pick;
      int          xpick;
      logic [15:0] xlen;
      pick  = $urandom_range(99);
      xpick = $urandom_range(99);
      if (xpick < 40) xlen = 16'd0;
      else if (xpick < 95) xlen = 16'($urandom_range(1, 6));
      else xlen = 16'h0100 | 16'($urandom_range(3));
      if (pick < 70) begin
         send_member(5'($urandom_range(31)), xlen, DMG_NONE);
      end else if (pick < 88) begin
         send_member(5'($urandom_range(31)), xlen, damage_type'($urandom_range(1, 5)));
      end else begin
         repeat ($urandom_range(1, 8)) begin
            send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
         end
      end
   endtask

   task automatic run_phase(input int req_pct, input int rsp_pct, input int until_count);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      while (bytes_sent < until_count) send_random_unit();
   endtask

   initial begin
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.in_byte    <= 8'd0;
      req_ch.new_member <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: shortest legal header with no optional sections; OS is the
      // last header byte, then payload bytes at both extremes.
      send_byte(gmhp_pkg::ID1_BYTE, 1'b1);
      send_byte(gmhp_pkg::ID2_BYTE, 1'b0);
      send_byte(gmhp_pkg::CM_DEFLATE, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'haa, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(gmhp_pkg::XFL_MAX, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b0);
      // Bad magic on a restart; the following byte must repeat the held error.
      send_byte(8'h1e, 1'b1);
      send_byte(gmhp_pkg::ID1_BYTE, 1'b0);
      // Bad method.
      send_byte(gmhp_pkg::ID1_BYTE, 1'b1);
      send_byte(gmhp_pkg::ID2_BYTE, 1'b0);
      send_byte(8'h09, 1'b0);
      // Bad flags: all bits set, the low five still show in header_flags.
      send_byte(gmhp_pkg::ID1_BYTE, 1'b1);
      send_byte(gmhp_pkg::ID2_BYTE, 1'b0);
      send_byte(gmhp_pkg::CM_DEFLATE, 1'b0);
      send_byte(8'hff, 1'b0);

      // Random traffic under three idle profiles: slow receiver, slow sender,
      // then full rate with a long receiver hold-off at its start.
      run_phase(18, 63, 700);
      run_phase(63, 18, 1400);
      hold_off_request = 1'b1;
      run_phase(0, 0, 2100);

      req_ch.valid <= 1'b0;
      // Drain: the watchdog catches results that never come.
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
         $display("** gzip_member_header_parser_core: PASSED **");
      end else begin
         $display("** gzip_member_header_parser_core: FAILED **");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/gmhp_pkg.sv
sv/gmhp_if.sv
sv/gmhp_step.sv
sv/gzip_member_header_parser_core.sv
dv/tb.sv
